>>> sv/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, constants and the Morse pattern table for the key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

	// default sizing
	localparam int TIMER_BITS_DEF = 16;
	localparam int MAX_MARKS_DEF  = 5;
	localparam int QUEUE_DEPTH    = 2;

	// configuration register file
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DASH_MIN   = 2'd0,
		REG_LETTER_GAP = 2'd1,
		REG_WORD_GAP   = 2'd2,
		REG_DEBOUNCE   = 2'd3
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] DASH_MIN_RST   = 16'd300;
	localparam logic [CFG_W-1:0] LETTER_GAP_RST = 16'd900;
	localparam logic [CFG_W-1:0] WORD_GAP_RST   = 16'd2200;
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd15;

	// longest pattern the table knows
	localparam int TAB_MARKS = 5;

	// ascii codes
	localparam logic [6:0] CODE_NONE = 7'd0;

	// one decoded tick
	typedef struct packed {
		logic       sidetone;
		logic       char_valid;
		logic [6:0] char_code;
		logic       unknown_symbol;
		logic       space_valid;
	} res_t;

	// pattern to ascii, mark i in bit i, 1 is a dash; CODE_NONE when no match
	function automatic logic [6:0] morse_lookup(input logic [2:0] cnt, input logic [4:0] pat);
		logic [6:0] code;
		code = CODE_NONE;
		unique case ({cnt, pat})
			{3'd1, 5'd0}:  code = 7'h45; // E
			{3'd1, 5'd1}:  code = 7'h54; // T
			{3'd2, 5'd2}:  code = 7'h41; // A
			{3'd2, 5'd0}:  code = 7'h49; // I
			{3'd2, 5'd3}:  code = 7'h4D; // M
			{3'd2, 5'd1}:  code = 7'h4E; // N
			{3'd3, 5'd1}:  code = 7'h44; // D
			{3'd3, 5'd3}:  code = 7'h47; // G
			{3'd3, 5'd5}:  code = 7'h4B; // K
			{3'd3, 5'd7}:  code = 7'h4F; // O
			{3'd3, 5'd2}:  code = 7'h52; // R
			{3'd3, 5'd0}:  code = 7'h53; // S
			{3'd3, 5'd4}:  code = 7'h55; // U
			{3'd3, 5'd6}:  code = 7'h57; // W
			{3'd4, 5'd1}:  code = 7'h42; // B
			{3'd4, 5'd5}:  code = 7'h43; // C
			{3'd4, 5'd4}:  code = 7'h46; // F
			{3'd4, 5'd0}:  code = 7'h48; // H
			{3'd4, 5'd14}: code = 7'h4A; // J
			{3'd4, 5'd2}:  code = 7'h4C; // L
			{3'd4, 5'd6}:  code = 7'h50; // P
			{3'd4, 5'd11}: code = 7'h51; // Q
			{3'd4, 5'd8}:  code = 7'h56; // V
			{3'd4, 5'd9}:  code = 7'h58; // X
			{3'd4, 5'd13}: code = 7'h59; // Y
			{3'd4, 5'd3}:  code = 7'h5A; // Z
			{3'd5, 5'd31}: code = 7'h30; // 0
			{3'd5, 5'd30}: code = 7'h31; // 1
			{3'd5, 5'd28}: code = 7'h32; // 2
			{3'd5, 5'd24}: code = 7'h33; // 3
			{3'd5, 5'd16}: code = 7'h34; // 4
			{3'd5, 5'd0}:  code = 7'h35; // 5
			{3'd5, 5'd1}:  code = 7'h36; // 6
			{3'd5, 5'd3}:  code = 7'h37; // 7
			{3'd5, 5'd7}:  code = 7'h38; // 8
			{3'd5, 5'd15}: code = 7'h39; // 9
			default:       code = CODE_NONE;
		endcase
		return code;
	endfunction

endpackage

>>> sv/mkd_queue.sv
// ----------------------------------------------------------------------------
// mkd_queue
// Small register queue that decouples the tick intake from the decoder and the
// decoder from the result consumer.
// ----------------------------------------------------------------------------
module mkd_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/mkd_core.sv
// ----------------------------------------------------------------------------
// mkd_core
// Decoder back end: timers, debounce, mark collection, letter and word gaps,
// plus the configuration registers.
// ----------------------------------------------------------------------------
module mkd_core #(
	parameter int TIMER_BITS = mkd_pkg::TIMER_BITS_DEF,
	parameter int MAX_MARKS  = mkd_pkg::MAX_MARKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mkd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           tick_en,
	input  logic                           key_pressed,
	output mkd_pkg::res_t                  res
);
	import mkd_pkg::*;

	localparam int TW  = TIMER_BITS;
	localparam int XW  = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int MCW = $clog2(MAX_MARKS + 2);
	localparam int MIW = $clog2(MAX_MARKS);

	// configuration
	logic [CFG_W-1:0] dash_min_q, letter_gap_q, word_gap_q, debounce_q;

	// decoder state
	logic                 key_down_q, letter_pending_q, word_space_done_q;
	logic                 sent_any_q, last_sent_space_q;
	logic [TW-1:0]        since_edge_q, press_length_q, since_release_q;
	logic [MAX_MARKS-1:0] mark_pattern_q;
	logic [MCW-1:0]       mark_count_q;

	// next values
	logic                 key_down_n, letter_pending_n, word_space_done_n;
	logic                 sent_any_n, last_sent_space_n;
	logic [TW-1:0]        since_edge_n, press_length_n, since_release_n;
	logic [MAX_MARKS-1:0] mark_pattern_n;
	logic [MCW-1:0]       mark_count_n;
	logic                 deb_ok;
	logic [6:0]           code;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_min_q   <= DASH_MIN_RST;
			letter_gap_q <= LETTER_GAP_RST;
			word_gap_q   <= WORD_GAP_RST;
			debounce_q   <= DEBOUNCE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DASH_MIN:   dash_min_q   <= cfg_data;
				REG_LETTER_GAP: letter_gap_q <= cfg_data;
				REG_WORD_GAP:   word_gap_q   <= cfg_data;
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	// one tick of decoding
	always_comb begin
		// timers advance and saturate first
		since_edge_n    = (since_edge_q == '1) ? since_edge_q : since_edge_q + 1'b1;
		since_release_n = (since_release_q == '1) ? since_release_q : since_release_q + 1'b1;
		press_length_n  = press_length_q;
		if (key_down_q && press_length_q != '1) begin
			press_length_n = press_length_q + 1'b1;
		end

		key_down_n        = key_down_q;
		letter_pending_n  = letter_pending_q;
		word_space_done_n = word_space_done_q;
		sent_any_n        = sent_any_q;
		last_sent_space_n = last_sent_space_q;
		mark_pattern_n    = mark_pattern_q;
		mark_count_n      = mark_count_q;

		res.sidetone       = key_pressed;
		res.char_valid     = 1'b0;
		res.char_code      = CODE_NONE;
		res.unknown_symbol = 1'b0;
		res.space_valid    = 1'b0;
		code               = CODE_NONE;

		deb_ok = XW'(since_edge_n) > XW'(debounce_q);

		// debounced key edges
		if (key_pressed && !key_down_q && deb_ok) begin
			key_down_n     = 1'b1;
			since_edge_n   = '0;
			press_length_n = '0;
		end else if (!key_pressed && key_down_q && deb_ok) begin
			key_down_n   = 1'b0;
			since_edge_n = '0;
			if (mark_count_q < MCW'(MAX_MARKS)) begin
				if (XW'(press_length_n) >= XW'(dash_min_q)) begin
					mark_pattern_n[mark_count_q[MIW-1:0]] = 1'b1;
				end
				mark_count_n = mark_count_q + 1'b1;
			end else begin
				mark_count_n = MCW'(MAX_MARKS + 1);
			end
			since_release_n   = '0;
			letter_pending_n  = 1'b1;
			word_space_done_n = 1'b0;
		end

		// letter gap ends the letter
		if (letter_pending_n && !key_down_n &&
		    XW'(since_release_n) > XW'(letter_gap_q)) begin
			if (mark_count_n != '0 && mark_count_n <= MCW'(TAB_MARKS)) begin
				code = morse_lookup(mark_count_n[2:0], mark_pattern_n[TAB_MARKS-1:0]);
			end
			if (code != CODE_NONE) begin
				res.char_valid    = 1'b1;
				res.char_code     = code;
				sent_any_n        = 1'b1;
				last_sent_space_n = 1'b0;
			end else begin
				res.unknown_symbol = 1'b1;
			end
			mark_pattern_n   = '0;
			mark_count_n     = '0;
			letter_pending_n = 1'b0;
		end

		// word gap sends a single space
		if (!letter_pending_n && mark_count_n == '0 && !key_down_n && !word_space_done_n &&
		    sent_any_n && !last_sent_space_n &&
		    XW'(since_release_n) > XW'(word_gap_q)) begin
			res.space_valid   = 1'b1;
			word_space_done_n = 1'b1;
			last_sent_space_n = 1'b1;
		end
	end

	// state update on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q        <= 1'b0;
			letter_pending_q  <= 1'b0;
			word_space_done_q <= 1'b1;
			sent_any_q        <= 1'b0;
			last_sent_space_q <= 1'b0;
			since_edge_q      <= '1;
			press_length_q    <= '0;
			since_release_q   <= '1;
			mark_pattern_q    <= '0;
			mark_count_q      <= '0;
		end else if (tick_en) begin
			key_down_q        <= key_down_n;
			letter_pending_q  <= letter_pending_n;
			word_space_done_q <= word_space_done_n;
			sent_any_q        <= sent_any_n;
			last_sent_space_q <= last_sent_space_n;
			since_edge_q      <= since_edge_n;
			press_length_q    <= press_length_n;
			since_release_q   <= since_release_n;
			mark_pattern_q    <= mark_pattern_n;
			mark_count_q      <= mark_count_n;
		end
	end

endmodule

>>> sv/morse_key_decoder_unit.sv
// path: a tick is queued at intake, the core decodes it, the result is queued
// throughput: one tick per cycle, sustained while pop keeps up with push
// the core sets the rate, retiring one queued tick per cycle while the result
// queue has room; two-entry queues flank it, so a stall spreads once they fill
// reset: arst_n low clears both queues, the decoder state and loads the default
// timing registers; no clearing pass is needed
// ----------------------------------------------------------------------------
// morse_key_decoder_unit
// Straight-key Morse decoder: tick intake queue, decoder core, result queue.
// ----------------------------------------------------------------------------
module morse_key_decoder_unit #(
	parameter int TIMER_BITS = mkd_pkg::TIMER_BITS_DEF,
	parameter int MAX_MARKS  = mkd_pkg::MAX_MARKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mkd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic                          key_pressed,
	output logic                          empty,
	input  logic                          pop,
	output logic                          sidetone,
	output logic                          char_valid,
	output logic [6:0]                    char_code,
	output logic                          unknown_symbol,
	output logic                          space_valid
);
	import mkd_pkg::*;

	logic in_empty, in_key, out_full, tick_en;
	res_t core_res, out_res;

	// core retires one tick when there is one and room for its result
	assign tick_en = !in_empty && !out_full;

	// front: tick intake
	mkd_queue #(
		.WIDTH (1),
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (key_pressed),
		.full    (full),
		.rd_en   (tick_en),
		.rd_data (in_key),
		.empty   (in_empty)
	);

	// back: decoder
	mkd_core #(
		.TIMER_BITS (TIMER_BITS),
		.MAX_MARKS  (MAX_MARKS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick_en     (tick_en),
		.key_pressed (in_key),
		.res         (core_res)
	);

	// result queue
	mkd_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tick_en),
		.wr_data (core_res),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_res),
		.empty   (empty)
	);

	assign sidetone       = out_res.sidetone;
	assign char_valid     = out_res.char_valid;
	assign char_code      = out_res.char_code;
	assign unknown_symbol = out_res.unknown_symbol;
	assign space_valid    = out_res.space_valid;

endmodule

>>> sv/mkd_checker.sv
// ----------------------------------------------------------------------------
// mkd_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mkd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       sidetone,
	input logic       char_valid,
	input logic [6:0] char_code,
	input logic       unknown_symbol,
	input logic       space_valid
);

	// a letter either decodes or is flagged, never both
	a_char_or_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(char_valid && unknown_symbol))
		else $error("char_valid and unknown_symbol together");

	// no code without a character
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !char_valid) |-> (char_code == 7'd0))
		else $error("char_code nonzero without char_valid");

	// a waiting result stays until its transfer
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped before transfer");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(sidetone) && $stable(char_valid) &&
		$stable(char_code) && $stable(unknown_symbol) && $stable(space_valid)))
		else $error("stalled result changed");

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.sidetone       (sidetone),
	.char_valid     (char_valid),
	.char_code      (char_code),
	.unknown_symbol (unknown_symbol),
	.space_valid    (space_valid)
);

>>> verif/morse_key_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_decoder_unit_tb
// Drives keyed tick streams into the straight-key decoder through its intake
// queue, decodes the same ticks in a behavioral model and checks each result
// transfer in order, under random idling on both sides and queue back-pressure.
// ----------------------------------------------------------------------------
module morse_key_decoder_unit_tb;
	import mkd_pkg::*;

	localparam int TB_TIMER   = TIMER_BITS_DEF;
	localparam int TB_MARKS   = MAX_MARKS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int LEN_CAP    = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 key_pressed = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 sidetone;
	logic                 char_valid;
	logic [6:0]           char_code;
	logic                 unknown_symbol;
	logic                 space_valid;

	morse_key_decoder_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.key_pressed    (key_pressed),
		.empty          (empty),
		.pop            (pop),
		.sidetone       (sidetone),
		.char_valid     (char_valid),
		.char_code      (char_code),
		.unknown_symbol (unknown_symbol),
		.space_valid    (space_valid)
	);

	always #1 clk = ~clk;

	// morse table, A-Z then 0-9
	string morse_tab [36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
		".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
		"...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....",
		"--...", "---..", "----."
	};

	// timing registers as the decoder should hold them
	logic [CFG_W-1:0] r_dash_min   = DASH_MIN_RST;
	logic [CFG_W-1:0] r_letter_gap = LETTER_GAP_RST;
	logic [CFG_W-1:0] r_word_gap   = WORD_GAP_RST;
	logic [CFG_W-1:0] r_debounce   = DEBOUNCE_RST;

	// decoder state
	bit                m_key_down = 1'b0;
	bit                m_letter_pending = 1'b0;
	bit                m_word_space_done = 1'b1;
	bit                m_sent_any = 1'b0;
	bit                m_last_space = 1'b0;
	logic [TB_TIMER-1:0] m_since_edge = '1;
	logic [TB_TIMER-1:0] m_press_len = '0;
	logic [TB_TIMER-1:0] m_since_release = '1;
	logic [4:0]        m_pattern = '0;
	int unsigned       m_marks = 0;

	res_t decoded_q [$];
	int   ticks_sent = 0;
	int   err_count = 0;
	bit   calm = 1'b0;
	int   rx_hold = 0;

	function automatic logic [TB_TIMER-1:0] sat_up(logic [TB_TIMER-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// ascii of a mark pattern, CODE_NONE when nothing matches
	function automatic logic [6:0] table_code(logic [4:0] pat, int unsigned cnt);
		logic [4:0] bits;
		for (int i = 0; i < 36; i++) begin
			bits = '0;
			for (int n = 0; n < morse_tab[i].len(); n++)
				if (morse_tab[i][n] == "-")
					bits[n] = 1'b1;
			if (morse_tab[i].len() == cnt && bits == pat)
				return (i < 26) ? 7'("A" + i) : 7'("0" + i - 26);
		end
		return CODE_NONE;
	endfunction

	// one tick through the decoder: timers first, then edges, letter end, word space
	function automatic res_t decode_tick(bit pressed);
		res_t r;
		r = '0;
		r.sidetone = pressed;
		m_since_edge = sat_up(m_since_edge);
		m_since_release = sat_up(m_since_release);
		if (m_key_down)
			m_press_len = sat_up(m_press_len);

		if (pressed && !m_key_down && m_since_edge > r_debounce) begin
			m_key_down = 1'b1;
			m_since_edge = '0;
			m_press_len = '0;
		end else if (!pressed && m_key_down && m_since_edge > r_debounce) begin
			m_key_down = 1'b0;
			m_since_edge = '0;
			if (m_marks < TB_MARKS) begin
				if (m_press_len >= r_dash_min)
					m_pattern[m_marks] = 1'b1;
				m_marks++;
			end else begin
				m_marks = TB_MARKS + 1;
			end
			m_since_release = '0;
			m_letter_pending = 1'b1;
			m_word_space_done = 1'b0;
		end

		// letter gap exceeded
		if (m_letter_pending && !m_key_down && m_since_release > r_letter_gap) begin
			r.char_code = table_code(m_pattern, m_marks);
			if (r.char_code != CODE_NONE) begin
				r.char_valid = 1'b1;
				m_sent_any = 1'b1;
				m_last_space = 1'b0;
			end else begin
				r.unknown_symbol = 1'b1;
			end
			m_pattern = '0;
			m_marks = 0;
			m_letter_pending = 1'b0;
		end

		// word gap exceeded
		if (!m_letter_pending && m_marks == 0 && !m_key_down && !m_word_space_done &&
				m_sent_any && !m_last_space && m_since_release > r_word_gap) begin
			r.space_valid = 1'b1;
			m_word_space_done = 1'b1;
			m_last_space = 1'b1;
		end
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(99) < 90) ? $urandom_range(1, 3) : $urandom_range(20, 60);
	endfunction

	function automatic int cap(int v);
		return (v > LEN_CAP) ? LEN_CAP : v;
	endfunction

	// one tick transfer on the intake side
	task automatic send_tick(bit k);
		if (!calm && $urandom_range(99) < 12) begin
			repeat (gap_len()) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
		@(negedge clk);
		push <= 1'b1;
		key_pressed <= k;
		do @(posedge clk); while (full);
		decoded_q.push_back(decode_tick(k));
		ticks_sent++;
	endtask

	task automatic hold_level(bit level, int n);
		repeat (n) send_tick(level);
	endtask

	// sender waits until every result transfer has come back
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DASH_MIN:   r_dash_min = val;
			REG_LETTER_GAP: r_letter_gap = val;
			REG_WORD_GAP:   r_word_gap = val;
			REG_DEBOUNCE:   r_debounce = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_timing(int dash, int lgap, int wgap, int deb);
		drain();
		write_reg(REG_DASH_MIN, CFG_W'(dash));
		write_reg(REG_LETTER_GAP, CFG_W'(lgap));
		write_reg(REG_WORD_GAP, CFG_W'(wgap));
		write_reg(REG_DEBOUNCE, CFG_W'(deb));
	endtask

	// one press, dot or dash by length, now and then with a contact bounce
	task automatic key_mark(bit is_dash);
		int lo, dmin, len;
		lo = cap(int'(r_debounce) + 1);
		dmin = cap(int'(r_dash_min));
		if (is_dash)
			len = $urandom_range((dmin > lo) ? dmin : lo, ((dmin > lo) ? dmin : lo) + 3);
		else
			len = $urandom_range(lo, (dmin - 1 > lo) ? dmin - 1 : lo);
		if (len > 2 && $urandom_range(99) < 8) begin
			hold_level(1'b1, len / 2);
			send_tick(1'b0);
			hold_level(1'b1, len - len / 2);
		end else begin
			hold_level(1'b1, len);
		end
	endtask

	// key a dot/dash string, then a letter or word gap
	task automatic key_letter(string s);
		int lo;
		lo = cap(int'(r_debounce) + 1);
		for (int i = 0; i < s.len(); i++) begin
			key_mark(s[i] == "-");
			if (i + 1 < s.len())
				hold_level(1'b0, $urandom_range(lo, cap(int'(r_letter_gap) + 1)));
		end
		if ($urandom_range(99) < 60)
			hold_level(1'b0, cap(int'(r_letter_gap) + 2) + $urandom_range(2));
		else
			hold_level(1'b0, cap(int'(r_word_gap) + 2) + $urandom_range(3));
	endtask

	// mostly table letters, some random patterns up to seven marks, some raw noise
	task automatic test_random_keying(int n);
		int start, cnt, pick;
		string s;
		start = ticks_sent;
		while (ticks_sent - start < n) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				key_letter(morse_tab[$urandom_range(35)]);
			end else if (pick < 85) begin
				s = "";
				cnt = $urandom_range(1, 7);
				repeat (cnt) begin
					if ($urandom_range(1))
						s = {s, "-"};
					else
						s = {s, "."};
				end
				key_letter(s);
			end else begin
				repeat ($urandom_range(3, 15)) send_tick(1'($urandom_range(1)));
			end
		end
	endtask

	// reset timing, first press on a saturated edge timer
	task automatic test_reset_defaults();
		hold_level(1'b0, 2);
		hold_level(1'b1, 2);
	endtask

	// zero gaps: letter and space come out in the same tick
	task automatic test_short_gaps();
		set_timing(2, 0, 0, 0);
		hold_level(1'b0, 2);
		send_tick(1'b1);
		hold_level(1'b0, 2);
	endtask

	// six dots overflow the mark count and give an unknown letter, no space after it
	task automatic test_too_many_marks();
		set_timing(2, 2, 3, 0);
		repeat (6) begin
			send_tick(1'b1);
			send_tick(1'b0);
		end
		hold_level(1'b0, 3);
	endtask

	// lowest timing with no idling on either side
	task automatic test_steady_stream();
		set_timing(1, 0, 0, 0);
		calm = 1'b1;
		test_random_keying(250);
		calm = 1'b0;
	endtask

	// sender pauses until every result has come back, then resumes
	task automatic test_drain_pause();
		set_timing(6, 8, 8, 2);
		test_random_keying(200);
		drain();
		test_random_keying(200);
	endtask

	// register values one below the maximum, nothing but presses beyond the first edge
	task automatic test_max_timing();
		set_timing(65534, 65534, 65534, 65534);
		test_random_keying(60);
	endtask

	// receiver holds off while the sender keeps offering ticks
	task automatic test_backpressure();
		set_timing(2, 3, 6, 0);
		calm = 1'b1;
		rx_hold = 120;
		test_random_keying(40);
		calm = 1'b0;
	endtask

	// result side: random pop stalls, long hold when asked
	initial begin : result_taker
		int rx_stall;
		rx_stall = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				pop <= 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				pop <= 1'b0;
				rx_stall--;
			end else if (!calm && $urandom_range(99) < 20) begin
				pop <= 1'b0;
				rx_stall = gap_len() - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// compare each result transfer with the oldest decoded tick
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && pop && !empty) begin
			got = '{sidetone, char_valid, char_code, unknown_symbol, space_valid};
			if (decoded_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("result transfer with nothing expected: %p", got);
			end else begin
				want = decoded_q.pop_front();
				if (got.sidetone !== want.sidetone || got.char_valid !== want.char_valid ||
						got.char_code !== want.char_code ||
						got.unknown_symbol !== want.unknown_symbol ||
						got.space_valid !== want.space_valid) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: expected tone %b char %b code %h unk %b space %b",
							want.sidetone, want.char_valid, want.char_code,
							want.unknown_symbol, want.space_valid,
							", got tone %b char %b code %h unk %b space %b",
							got.sidetone, got.char_valid, got.char_code,
							got.unknown_symbol, got.space_valid);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("morse_key_decoder_unit_tb NOT OK");
		$finish;
	end

	// test sequence
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_short_gaps();
		test_too_many_marks();
		set_timing(3, 5, 10, 1);
		test_random_keying(450);
		test_steady_stream();
		test_drain_pause();
		test_max_timing();
		test_backpressure();
		test_random_keying(350);

		drain();
		repeat (8) @(posedge clk);
		if (decoded_q.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("morse_key_decoder_unit_tb OK");
		else
			$display("morse_key_decoder_unit_tb NOT OK");
		$finish;
	end

endmodule
